@@ design/memory_usage_pressure_monitor_assert.svh @@
// Assertion macros shared by the monitor's modules.
`ifndef MEMORY_USAGE_PRESSURE_MONITOR_ASSERT_SVH
`define MEMORY_USAGE_PRESSURE_MONITOR_ASSERT_SVH

// Overlapping implication checked at every edge outside reset.
`define MUPM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the next cycle.
`define MUPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/mupm_pkg.sv @@
`default_nettype none
package mupm_pkg;
    localparam int NUM_TYPES_DEF  = 7;
    localparam int PAGE_BYTES_DEF = 4096;
    localparam int BYTES_W = 48;
    localparam int CNT_W   = 32;
    localparam int SIZE_W  = 32;
    localparam int FRAG_W  = 7;
    localparam int TYPE_W  = 4;
    localparam logic [BYTES_W-1:0] LOW_THR_RST  = 48'd8388608;
    localparam logic [BYTES_W-1:0] CRIT_THR_RST = 48'd4194304;
    localparam logic [CNT_W-1:0]   FAIL_LIMIT   = 32'd10;
    localparam logic [FRAG_W-1:0]  FRAG_LIMIT   = 7'd60;
    localparam int RATIO_PCT = 5;
    localparam int RATIO_DEN = 100;

    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_FAIL  = 2'd2,
        MODE_QUERY = 2'd3
    } t_mode;

    typedef enum logic [0:0] {
        CFG_LOW  = 1'b0,
        CFG_CRIT = 1'b1
    } t_cfg_idx;

    // Classified event passed from the front to the back.
    typedef struct packed {
        t_mode              mode;
        logic [TYPE_W-1:0]  ty;
        logic [SIZE_W-1:0]  size;
        logic               over_page;
        logic               hi_frag;
    } t_event;
endpackage
`default_nettype wire

@@ design/mupm_front.sv @@
`default_nettype none
module mupm_front #(
    parameter int NUM_TYPES  = mupm_pkg::NUM_TYPES_DEF,
    parameter int PAGE_BYTES = mupm_pkg::PAGE_BYTES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [1:0]                i_mode,
    input  wire logic [mupm_pkg::TYPE_W-1:0] i_mem_type,
    input  wire logic [mupm_pkg::SIZE_W-1:0] i_size_bytes,
    input  wire logic [mupm_pkg::FRAG_W-1:0] i_fragmentation_pct,
    output logic                           o_q_valid,
    input  wire logic                      i_q_pop,
    output mupm_pkg::t_event               o_q_event
);
    import mupm_pkg::*;
    `include "memory_usage_pressure_monitor_assert.svh"

    // Two-entry queue.
    t_event     r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_event     w_ev;
    logic       w_push;

    always_comb begin
        w_ev.mode      = t_mode'(i_mode);
        w_ev.ty        = ({1'b0, i_mem_type} >= (TYPE_W+1)'(NUM_TYPES)) ? '0 : i_mem_type;
        w_ev.size      = i_size_bytes;
        w_ev.over_page = i_size_bytes > SIZE_W'(PAGE_BYTES);
        w_ev.hi_frag   = i_fragmentation_pct > FRAG_LIMIT;
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_event = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_ev;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end

    `MUPM_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_q_pop, r_cnt != 2'd0)
    `MUPM_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= 2'd2)
    `MUPM_ASSERT_IMP(a_ptr_sync, i_clk, i_rst_n, r_cnt == 2'd0 || r_cnt == 2'd2, r_wp == r_rp)
endmodule
`default_nettype wire

@@ design/mupm_back.sv @@
`default_nettype none
module mupm_back #(
    parameter int NUM_TYPES = mupm_pkg::NUM_TYPES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_q_valid,
    output logic                              o_q_pop,
    input  wire mupm_pkg::t_event             i_q_event,
    input  wire logic [mupm_pkg::BYTES_W-1:0] i_low_thr,
    input  wire logic [mupm_pkg::BYTES_W-1:0] i_crit_thr,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [mupm_pkg::BYTES_W-1:0]      o_type_current_bytes,
    output logic [mupm_pkg::BYTES_W-1:0]      o_type_peak_bytes,
    output logic [mupm_pkg::CNT_W-1:0]        o_type_alloc_count,
    output logic [mupm_pkg::CNT_W-1:0]        o_type_failed_count,
    output logic [mupm_pkg::CNT_W-1:0]        o_type_large_count,
    output logic [mupm_pkg::BYTES_W-1:0]      o_total_current_bytes,
    output logic [mupm_pkg::BYTES_W-1:0]      o_total_peak_bytes,
    output logic [mupm_pkg::CNT_W-1:0]        o_total_failed_count,
    output logic                              o_warning_raised,
    output logic                              o_oom_raised,
    output logic                              o_under_pressure,
    output logic [mupm_pkg::CNT_W-1:0]        o_warning_count
);
    import mupm_pkg::*;
    `include "memory_usage_pressure_monitor_assert.svh"

    localparam int IDX_W = $clog2(NUM_TYPES);

    logic [BYTES_W-1:0] r_cur  [NUM_TYPES];
    logic [BYTES_W-1:0] r_peak [NUM_TYPES];
    logic [CNT_W-1:0]   r_allc [NUM_TYPES];
    logic [CNT_W-1:0]   r_fail [NUM_TYPES];
    logic [CNT_W-1:0]   r_lrg  [NUM_TYPES];
    logic [BYTES_W-1:0] r_scur, r_speak;
    logic [CNT_W-1:0]   r_sallc, r_sfail, r_swarn;

    logic [BYTES_W-1:0] n_cur, n_peak, n_scur, n_speak;
    logic [CNT_W-1:0]   n_allc, n_fail, n_lrg, n_sallc, n_sfail, n_swarn;
    logic               n_warn, n_oom, n_hi_use, n_hi_frag;
    logic [IDX_W-1:0]   w_ix;
    logic [BYTES_W:0]   w_tsum, w_ssum;
    logic               w_take;

    // Failure-ratio test runs in a second stage: fail*100 > 5*allocs + remainder
    // is equivalent to floor(fail*100/allocs) > 5, i.e. fail*100 >= 6*allocs.
    logic               r_s2;
    logic [CNT_W-1:0]   r_s2_fail, r_s2_allc;
    logic               r_s2_hi_use, r_s2_hi_frag, r_s2_crit;
    logic [BYTES_W-1:0] r_s2_cur, r_s2_peak, r_s2_scur, r_s2_speak;
    logic [CNT_W-1:0]   r_s2_allcT, r_s2_failT, r_s2_lrg, r_s2_swarn;
    logic               r_s2_warn, r_s2_oom;
    logic [CNT_W+7:0]   w_lhs, w_rhs;
    logic               w_hi_fail;
    logic [1:0]         w_signs;

    assign w_ix   = i_q_event.ty[IDX_W-1:0];
    // Back takes no new transaction while stage 2 holds one; stall when stage 2 or output busy.
    assign w_take = i_q_valid && !r_s2 && !(o_valid && !i_ready);
    assign o_q_pop = w_take;

    always_comb begin
        n_cur  = r_cur[w_ix];
        n_peak = r_peak[w_ix];
        n_allc = r_allc[w_ix];
        n_fail = r_fail[w_ix];
        n_lrg  = r_lrg[w_ix];
        n_scur = r_scur;
        n_speak = r_speak;
        n_sallc = r_sallc;
        n_sfail = r_sfail;
        n_swarn = r_swarn;
        n_warn = 1'b0;
        n_oom  = 1'b0;
        w_tsum = {1'b0, r_cur[w_ix]} + {{(BYTES_W-SIZE_W+1){1'b0}}, i_q_event.size};
        w_ssum = {1'b0, r_scur} + {{(BYTES_W-SIZE_W+1){1'b0}}, i_q_event.size};
        unique case (i_q_event.mode)
            MODE_ALLOC: begin
                n_allc  = r_allc[w_ix] + 1'b1;
                n_cur   = w_tsum[BYTES_W] ? '1 : w_tsum[BYTES_W-1:0];
                if (n_cur > n_peak) n_peak = n_cur;
                if (i_q_event.over_page) n_lrg = r_lrg[w_ix] + 1'b1;
                n_sallc = r_sallc + 1'b1;
                n_scur  = w_ssum[BYTES_W] ? '1 : w_ssum[BYTES_W-1:0];
                if (n_scur > n_speak) n_speak = n_scur;
                if (n_scur > i_low_thr) begin
                    n_warn  = 1'b1;
                    n_swarn = r_swarn + 1'b1;
                end
            end
            MODE_FREE: begin
                n_cur  = (r_cur[w_ix] >= BYTES_W'(i_q_event.size)) ?
                         r_cur[w_ix] - BYTES_W'(i_q_event.size) : '0;
                n_scur = (r_scur >= BYTES_W'(i_q_event.size)) ?
                         r_scur - BYTES_W'(i_q_event.size) : '0;
            end
            MODE_FAIL: begin
                n_fail  = r_fail[w_ix] + 1'b1;
                n_sfail = r_sfail + 1'b1;
                n_oom   = i_q_event.over_page || (n_sfail > FAIL_LIMIT);
            end
            MODE_QUERY: begin
            end
            default: begin
            end
        endcase
        n_hi_use  = n_scur > i_low_thr;
        n_hi_frag = i_q_event.hi_frag;
    end

    always_comb begin
        w_lhs     = {8'd0, r_s2_fail} * (CNT_W+8)'(RATIO_DEN);
        w_rhs     = {8'd0, r_s2_allc} * (CNT_W+8)'(RATIO_PCT + 1);
        w_hi_fail = (r_s2_fail > FAIL_LIMIT) && (r_s2_allc != '0) && (w_lhs >= w_rhs);
        w_signs   = {1'b0, r_s2_hi_use} + {1'b0, w_hi_fail} + {1'b0, r_s2_hi_frag};
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_s2_fail  <= n_sfail;
            r_s2_allc  <= n_sallc;
            r_s2_hi_use <= n_hi_use;
            r_s2_hi_frag <= n_hi_frag;
            r_s2_crit  <= n_scur > i_crit_thr;
            r_s2_cur   <= n_cur;
            r_s2_peak  <= n_peak;
            r_s2_allcT <= n_allc;
            r_s2_failT <= n_fail;
            r_s2_lrg   <= n_lrg;
            r_s2_scur  <= n_scur;
            r_s2_speak <= n_speak;
            r_s2_swarn <= n_swarn;
            r_s2_warn  <= n_warn;
            r_s2_oom   <= n_oom;
        end
        if (r_s2) begin
            o_type_current_bytes  <= r_s2_cur;
            o_type_peak_bytes     <= r_s2_peak;
            o_type_alloc_count    <= r_s2_allcT;
            o_type_failed_count   <= r_s2_failT;
            o_type_large_count    <= r_s2_lrg;
            o_total_current_bytes <= r_s2_scur;
            o_total_peak_bytes    <= r_s2_speak;
            o_total_failed_count  <= r_s2_fail;
            o_warning_raised      <= r_s2_warn;
            o_oom_raised          <= r_s2_oom;
            o_under_pressure      <= r_s2_crit || (w_signs >= 2'd2);
            o_warning_count       <= r_s2_swarn;
        end
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_TYPES; k++) begin
                r_cur[k]  <= '0;
                r_peak[k] <= '0;
                r_allc[k] <= '0;
                r_fail[k] <= '0;
                r_lrg[k]  <= '0;
            end
            r_scur  <= '0;
            r_speak <= '0;
            r_sallc <= '0;
            r_sfail <= '0;
            r_swarn <= '0;
            r_s2    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_cur[w_ix]  <= n_cur;
                r_peak[w_ix] <= n_peak;
                r_allc[w_ix] <= n_allc;
                r_fail[w_ix] <= n_fail;
                r_lrg[w_ix]  <= n_lrg;
                r_scur  <= n_scur;
                r_speak <= n_speak;
                r_sallc <= n_sallc;
                r_sfail <= n_sfail;
                r_swarn <= n_swarn;
            end
            r_s2 <= w_take;
            if (r_s2) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
        end
    end

    `MUPM_ASSERT_NEXT(a_take_to_s2, i_clk, i_rst_n, w_take, r_s2)
    `MUPM_ASSERT_NEXT(a_s2_to_out, i_clk, i_rst_n, r_s2, o_valid)
    `MUPM_ASSERT_IMP(a_peak_ge_cur, i_clk, i_rst_n, 1'b1, r_speak >= r_scur)
endmodule
`default_nettype wire

@@ design/memory_usage_pressure_monitor.sv @@
`default_nettype none
// Memory usage and pressure monitor. Each input transaction is an allocation,
// free, failed allocation or query for one memory type; the block updates that
// type's byte and event counters plus the totals and returns one result
// transaction with the updated figures, warning and out-of-memory flags and a
// pressure verdict. A front stage classifies events into a two-entry queue; a
// back stage performs the counter update and registers it, runs the
// failure-ratio test on the registered values, then holds the result in an
// output register. The back stage takes no new event while the previous one
// is in its second stage or while the output holds a result not yet accepted.
// The user must write the threshold registers through the plain write port
// only while the block is idle; the block itself does not enforce this.
module memory_usage_pressure_monitor #(
    parameter int NUM_TYPES  = mupm_pkg::NUM_TYPES_DEF,
    parameter int PAGE_BYTES = mupm_pkg::PAGE_BYTES_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_index,
    input  wire logic [mupm_pkg::BYTES_W-1:0]   i_cfg_data,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [1:0]                     i_mode,
    input  wire logic [mupm_pkg::TYPE_W-1:0]    i_mem_type,
    input  wire logic [mupm_pkg::SIZE_W-1:0]    i_size_bytes,
    input  wire logic [mupm_pkg::FRAG_W-1:0]    i_fragmentation_pct,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [mupm_pkg::BYTES_W-1:0]        o_type_current_bytes,
    output logic [mupm_pkg::BYTES_W-1:0]        o_type_peak_bytes,
    output logic [mupm_pkg::CNT_W-1:0]          o_type_alloc_count,
    output logic [mupm_pkg::CNT_W-1:0]          o_type_failed_count,
    output logic [mupm_pkg::CNT_W-1:0]          o_type_large_count,
    output logic [mupm_pkg::BYTES_W-1:0]        o_total_current_bytes,
    output logic [mupm_pkg::BYTES_W-1:0]        o_total_peak_bytes,
    output logic [mupm_pkg::CNT_W-1:0]          o_total_failed_count,
    output logic                                o_warning_raised,
    output logic                                o_oom_raised,
    output logic                                o_under_pressure,
    output logic [mupm_pkg::CNT_W-1:0]          o_warning_count
);
    import mupm_pkg::*;

    logic [BYTES_W-1:0] r_low_thr, r_crit_thr;
    logic               w_q_valid, w_q_pop;
    t_event             w_q_event;

    // Threshold registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_thr  <= LOW_THR_RST;
            r_crit_thr <= CRIT_THR_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_LOW) r_low_thr <= i_cfg_data;
            else r_crit_thr <= i_cfg_data;
        end
    end

    mupm_front #(.NUM_TYPES(NUM_TYPES), .PAGE_BYTES(PAGE_BYTES)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_mode, .i_mem_type,
        .i_size_bytes, .i_fragmentation_pct,
        .o_q_valid(w_q_valid), .i_q_pop(w_q_pop), .o_q_event(w_q_event)
    );

    mupm_back #(.NUM_TYPES(NUM_TYPES)) u_back (
        .i_clk, .i_rst_n,
        .i_q_valid(w_q_valid), .o_q_pop(w_q_pop), .i_q_event(w_q_event),
        .i_low_thr(r_low_thr), .i_crit_thr(r_crit_thr),
        .o_valid, .i_ready,
        .o_type_current_bytes, .o_type_peak_bytes, .o_type_alloc_count,
        .o_type_failed_count, .o_type_large_count, .o_total_current_bytes,
        .o_total_peak_bytes, .o_total_failed_count, .o_warning_raised,
        .o_oom_raised, .o_under_pressure, .o_warning_count
    );
endmodule
`default_nettype wire

@@ tb/sv/memory_usage_pressure_monitor_tb.sv @@
`timescale 1ns / 1ps

module memory_usage_pressure_monitor_tb;
    import mupm_pkg::*;

    // Run limit in clock cycles. The slowest correct run is roughly the item
    // count times the issue interval, stretched by idle cycles on both sides and
    // the drains between phases. The limit leaves a wide margin over that.
    localparam int CYCLE_LIMIT = 50_000;
    localparam int TAIL_CYCLES = 8;
    localparam int SAT_BURST   = 16;
    localparam logic [BYTES_W-1:0] MAX48 = {BYTES_W{1'b1}};

    // One result transaction, with every field the block reports.
    typedef struct packed {
        logic [BYTES_W-1:0] type_cur;
        logic [BYTES_W-1:0] type_peak;
        logic [CNT_W-1:0]   type_allocs;
        logic [CNT_W-1:0]   type_fails;
        logic [CNT_W-1:0]   type_large;
        logic [BYTES_W-1:0] total_cur;
        logic [BYTES_W-1:0] total_peak;
        logic [CNT_W-1:0]   total_fails;
        logic               warn;
        logic               oom;
        logic               press;
        logic [CNT_W-1:0]   warn_count;
    } usage_report_t;

    // One row of the directed stimulus. When known is set, the expected
    // report is typed into the row instead of being taken from the predictor.
    typedef struct {
        t_mode              mode;
        logic [TYPE_W-1:0]  mem_type;
        logic [SIZE_W-1:0]  size;
        logic [FRAG_W-1:0]  frag;
        bit                 known;
        usage_report_t      report;
    } event_row_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic                 i_cfg_index;
    logic [BYTES_W-1:0]   i_cfg_data;
    logic                 i_valid;
    logic                 o_ready;
    logic [1:0]           i_mode;
    logic [TYPE_W-1:0]    i_mem_type;
    logic [SIZE_W-1:0]    i_size_bytes;
    logic [FRAG_W-1:0]    i_fragmentation_pct;
    logic                 o_valid;
    logic                 i_ready;
    logic [BYTES_W-1:0]   o_type_current_bytes;
    logic [BYTES_W-1:0]   o_type_peak_bytes;
    logic [CNT_W-1:0]     o_type_alloc_count;
    logic [CNT_W-1:0]     o_type_failed_count;
    logic [CNT_W-1:0]     o_type_large_count;
    logic [BYTES_W-1:0]   o_total_current_bytes;
    logic [BYTES_W-1:0]   o_total_peak_bytes;
    logic [CNT_W-1:0]     o_total_failed_count;
    logic                 o_warning_raised;
    logic                 o_oom_raised;
    logic                 o_under_pressure;
    logic [CNT_W-1:0]     o_warning_count;

    memory_usage_pressure_monitor uut (.*);

    // Shadow copy of the block's accounting state and threshold registers.
    logic [BYTES_W-1:0] acct_cur   [NUM_TYPES_DEF];
    logic [BYTES_W-1:0] acct_peak  [NUM_TYPES_DEF];
    logic [CNT_W-1:0]   acct_allocs[NUM_TYPES_DEF];
    logic [CNT_W-1:0]   acct_fails [NUM_TYPES_DEF];
    logic [CNT_W-1:0]   acct_large [NUM_TYPES_DEF];
    logic [BYTES_W-1:0] sum_cur, sum_peak, low_thr, crit_thr;
    logic [CNT_W-1:0]   sum_allocs, sum_fails, sum_warns;

    usage_report_t pending_reports[$];
    event_row_t    event_rows[$];
    int            mismatches = 0;
    int            cycles = 0;
    bit            steady = 0;   // when set, neither side inserts idle cycles

    // The clock runs with a 12 ns period.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Saturating add into a 48-bit byte count.
    function automatic logic [BYTES_W-1:0] add_sat(logic [BYTES_W-1:0] a,
                                                   logic [SIZE_W-1:0] b);
        logic [BYTES_W:0] s;
        s = {1'b0, a} + (BYTES_W+1)'(b);
        return s[BYTES_W] ? MAX48 : s[BYTES_W-1:0];
    endfunction

    // Applies one event to the shadow state and returns the report that the
    // block should produce for it. The pressure verdict looks at the state
    // after the event, and the failure ratio is done in 64 bits so it is exact.
    function automatic usage_report_t account_event(t_mode mode, logic [TYPE_W-1:0] mt,
                                                    logic [SIZE_W-1:0] size,
                                                    logic [FRAG_W-1:0] frag);
        usage_report_t r;
        int ty;
        logic hi_use, hi_fail, hi_frag;
        int signs;
        ty = (mt >= NUM_TYPES_DEF) ? 0 : int'(mt);
        r.warn = 1'b0;
        r.oom  = 1'b0;
        case (mode)
            MODE_ALLOC: begin
                acct_allocs[ty] = acct_allocs[ty] + 1;
                acct_cur[ty] = add_sat(acct_cur[ty], size);
                if (acct_cur[ty] > acct_peak[ty]) acct_peak[ty] = acct_cur[ty];
                if (size > PAGE_BYTES_DEF) acct_large[ty] = acct_large[ty] + 1;
                sum_allocs = sum_allocs + 1;
                sum_cur = add_sat(sum_cur, size);
                if (sum_cur > sum_peak) sum_peak = sum_cur;
                if (sum_cur > low_thr) begin
                    r.warn = 1'b1;
                    sum_warns = sum_warns + 1;
                end
            end
            MODE_FREE: begin
                acct_cur[ty] = (acct_cur[ty] >= BYTES_W'(size)) ?
                               acct_cur[ty] - BYTES_W'(size) : '0;
                sum_cur = (sum_cur >= BYTES_W'(size)) ? sum_cur - BYTES_W'(size) : '0;
            end
            MODE_FAIL: begin
                acct_fails[ty] = acct_fails[ty] + 1;
                sum_fails = sum_fails + 1;
                r.oom = (size > PAGE_BYTES_DEF) || (sum_fails > FAIL_LIMIT);
            end
            default: ;
        endcase
        hi_use  = sum_cur > low_thr;
        hi_fail = (sum_fails > FAIL_LIMIT) && (sum_allocs != 0) &&
                  ((64'(sum_fails) * RATIO_DEN) / 64'(sum_allocs) > RATIO_PCT);
        hi_frag = frag > FRAG_LIMIT;
        signs = int'(hi_use) + int'(hi_fail) + int'(hi_frag);
        r.press       = (sum_cur > crit_thr) || (signs >= 2);
        r.type_cur    = acct_cur[ty];
        r.type_peak   = acct_peak[ty];
        r.type_allocs = acct_allocs[ty];
        r.type_fails  = acct_fails[ty];
        r.type_large  = acct_large[ty];
        r.total_cur   = sum_cur;
        r.total_peak  = sum_peak;
        r.total_fails = sum_fails;
        r.warn_count  = sum_warns;
        return r;
    endfunction

    // Prints one line for a mismatch and counts it. Printing stops after a
    // few dozen so a broken block does not flood the log.
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
                     cycles, what, got, want);
    endtask

    // Threshold register write, mirrored into the shadow copy. The enable
    // is lowered again before the task returns.
    task automatic write_threshold(t_cfg_idx idx, logic [BYTES_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_LOW) low_thr = value;
        else crit_thr = value;
    endtask

    // Sends one event transaction. Unless steady is set, idle cycles may be inserted
    // before valid is raised, so valid is never dropped and raised in the same time step.
    // The expected report is queued at the edge where the block accepts it.
    task automatic send_event(event_row_t ev);
        usage_report_t r;
        while (!steady && $urandom_range(0, 99) < 11) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid             <= 1'b1;
        i_mode              <= ev.mode;
        i_mem_type          <= ev.mem_type;
        i_size_bytes        <= ev.size;
        i_fragmentation_pct <= ev.frag;
        do @(posedge i_clk); while (!o_ready);
        r = account_event(ev.mode, ev.mem_type, ev.size, ev.frag);
        pending_reports.push_back(ev.known ? ev.report : r);
    endtask

    // Waits until every queued report has come back, then lets the pipeline
    // settle before the caller touches the threshold registers.
    task automatic drain;
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_reports.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    function automatic event_row_t mk_row(t_mode m, logic [TYPE_W-1:0] t,
                                          logic [SIZE_W-1:0] s, logic [FRAG_W-1:0] f);
        event_row_t ev;
        ev.mode = m;
        ev.mem_type = t;
        ev.size = s;
        ev.frag = f;
        ev.known = 1'b0;
        ev.report = '0;
        return ev;
    endfunction

    function automatic event_row_t mk_known(t_mode m, logic [TYPE_W-1:0] t,
                                            logic [SIZE_W-1:0] s, logic [FRAG_W-1:0] f,
                                            usage_report_t r);
        event_row_t ev;
        ev = mk_row(m, t, s, f);
        ev.known = 1'b1;
        ev.report = r;
        return ev;
    endfunction

    // Random event. Most traffic is small allocations and frees so that the
    // byte counts move around the thresholds; a share of failed allocations
    // pushes the failure count and ratio past their limits.
    function automatic event_row_t random_event();
        event_row_t ev;
        int pick;
        logic [SIZE_W-1:0] s;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0:       s = $urandom();
            1:       s = PAGE_BYTES_DEF + $urandom_range(0, 1) - 0;
            2, 3:    s = $urandom_range(0, 255);
            default: s = $urandom_range(0, 1 << 20);
        endcase
        if (pick < 45)      ev = mk_row(MODE_ALLOC, '0, s, '0);
        else if (pick < 75) ev = mk_row(MODE_FREE,  '0, s, '0);
        else if (pick < 90) ev = mk_row(MODE_FAIL,  '0, s, '0);
        else                ev = mk_row(MODE_QUERY, '0, s, '0);
        ev.mem_type = TYPE_W'($urandom_range(0, 15));
        ev.frag = FRAG_W'($urandom_range(0, 127));
        return ev;
    endfunction

    // Result side: random back-pressure, cycle counter and the checker. All
    // values are sampled at the clock edge, before the block updates them.
    always @(posedge i_clk) begin
        usage_report_t w;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
        i_ready <= steady || ($urandom_range(0, 99) >= 11);
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_reports.size() == 0) begin
                report_mismatch("unexpected result transaction", 0, 0);
            end else begin
                w = pending_reports.pop_front();
                if (o_type_current_bytes != w.type_cur)
                    report_mismatch("type_current_bytes", o_type_current_bytes, w.type_cur);
                if (o_type_peak_bytes != w.type_peak)
                    report_mismatch("type_peak_bytes", o_type_peak_bytes, w.type_peak);
                if (o_type_alloc_count != w.type_allocs)
                    report_mismatch("type_alloc_count", o_type_alloc_count, w.type_allocs);
                if (o_type_failed_count != w.type_fails)
                    report_mismatch("type_failed_count", o_type_failed_count, w.type_fails);
                if (o_type_large_count != w.type_large)
                    report_mismatch("type_large_count", o_type_large_count, w.type_large);
                if (o_total_current_bytes != w.total_cur)
                    report_mismatch("total_current_bytes", o_total_current_bytes,
                                    w.total_cur);
                if (o_total_peak_bytes != w.total_peak)
                    report_mismatch("total_peak_bytes", o_total_peak_bytes, w.total_peak);
                if (o_total_failed_count != w.total_fails)
                    report_mismatch("total_failed_count", o_total_failed_count,
                                    w.total_fails);
                if (o_warning_raised != w.warn)
                    report_mismatch("warning_raised", o_warning_raised, w.warn);
                if (o_oom_raised != w.oom)
                    report_mismatch("oom_raised", o_oom_raised, w.oom);
                if (o_under_pressure != w.press)
                    report_mismatch("under_pressure", o_under_pressure, w.press);
                if (o_warning_count != w.warn_count)
                    report_mismatch("warning_count", o_warning_count, w.warn_count);
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_LOW;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_mode = MODE_QUERY;
        i_mem_type = '0;
        i_size_bytes = '0;
        i_fragmentation_pct = '0;
        for (int k = 0; k < NUM_TYPES_DEF; k++) begin
            acct_cur[k] = '0;
            acct_peak[k] = '0;
            acct_allocs[k] = '0;
            acct_fails[k] = '0;
            acct_large[k] = '0;
        end
        sum_cur = '0;
        sum_peak = '0;
        sum_allocs = '0;
        sum_fails = '0;
        sum_warns = '0;
        low_thr = LOW_THR_RST;
        crit_thr = CRIT_THR_RST;

        // Directed rows. The first four have hand-computed reports: a query
        // right after reset, a maximum-size allocation to an out-of-range type
        // (it lands in type 0 and trips warning and pressure), a free of the
        // same size that empties it, and a failed allocation above page size.
        event_rows.push_back(mk_known(MODE_QUERY, 4'd0, 32'd0, 7'd0, '0));
        event_rows.push_back(mk_known(MODE_ALLOC, 4'd15, 32'hFFFF_FFFF, 7'd100,
            '{48'hFFFF_FFFF, 48'hFFFF_FFFF, 32'd1, 32'd0, 32'd1,
              48'hFFFF_FFFF, 48'hFFFF_FFFF, 32'd0, 1'b1, 1'b0, 1'b1, 32'd1}));
        event_rows.push_back(mk_known(MODE_FREE, 4'd0, 32'hFFFF_FFFF, 7'd0,
            '{48'd0, 48'hFFFF_FFFF, 32'd1, 32'd0, 32'd1,
              48'd0, 48'hFFFF_FFFF, 32'd0, 1'b0, 1'b0, 1'b0, 32'd1}));
        event_rows.push_back(mk_known(MODE_FAIL, 4'd1, 32'd4097, 7'd127,
            '{48'd0, 48'd0, 32'd0, 32'd1, 32'd0,
              48'd0, 48'hFFFF_FFFF, 32'd1, 1'b0, 1'b1, 1'b0, 32'd1}));
        // Page-size boundary, the remaining valid types, the first out-of-range codes,
        // a free larger than what the type holds, and the fragmentation edge.
        event_rows.push_back(mk_row(MODE_ALLOC, 4'd2, 32'd4096, 7'd60));
        event_rows.push_back(mk_row(MODE_ALLOC, 4'd3, 32'd4097, 7'd61));
        event_rows.push_back(mk_row(MODE_ALLOC, 4'd6, 32'd5000000, 7'd0));
        event_rows.push_back(mk_row(MODE_ALLOC, 4'd7, 32'd100, 7'd0));
        event_rows.push_back(mk_row(MODE_ALLOC, 4'd8, 32'd200, 7'd0));
        event_rows.push_back(mk_row(MODE_FREE, 4'd3, 32'd10000, 7'd0));
        event_rows.push_back(mk_row(MODE_QUERY, 4'd6, 32'hFFFF_FFFF, 7'd127));
        event_rows.push_back(mk_row(MODE_FAIL, 4'd4, 32'd0, 7'd0));
        event_rows.push_back(mk_row(MODE_FREE, 4'd5, 32'd0, 7'd0));
        // Enough failures to pass the limit of ten, with high fragmentation so
        // the failure ratio and fragmentation together raise pressure.
        for (int k = 0; k < 9; k++)
            event_rows.push_back(mk_row(MODE_FAIL, 4'(k), 32'd16, 7'd90));
        event_rows.push_back(mk_row(MODE_QUERY, 4'd5, 32'd0, 7'd61));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        steady = 1'b1;
        foreach (event_rows[k]) send_event(event_rows[k]);
        steady = 1'b0;
        // Hold the sender until every report is back.
        drain();

        // Zero thresholds: every allocation that leaves bytes in use warns, and any bytes mean pressure.
        write_threshold(CFG_LOW, '0);
        write_threshold(CFG_CRIT, '0);
        for (int k = 0; k < 250; k++) send_event(random_event());
        drain();

        // Thresholds in the range the random sizes reach.
        write_threshold(CFG_LOW, 48'($urandom_range(1 << 18, 1 << 22)));
        write_threshold(CFG_CRIT, 48'($urandom_range(1 << 20, 1 << 24)));
        steady = 1'b1;
        for (int k = 0; k < 150; k++) send_event(random_event());
        steady = 1'b0;
        for (int k = 0; k < 150; k++) send_event(random_event());
        drain();

        // Maximum thresholds, then a burst of maximum-size allocations into
        // type 2, and frees after.
        write_threshold(CFG_LOW, MAX48);
        write_threshold(CFG_CRIT, MAX48);
        for (int k = 0; k < SAT_BURST; k++)
            send_event(mk_row(MODE_ALLOC, 4'd2, 32'hFFFF_FFFF, 7'($urandom_range(0, 127))));
        for (int k = 0; k < 4; k++)
            send_event(mk_row(MODE_FREE, 4'd2, 32'hFFFF_FFFF, 7'd0));
        drain();

        // Back to the reset values for the last random stretch.
        write_threshold(CFG_LOW, LOW_THR_RST);
        write_threshold(CFG_CRIT, CRIT_THR_RST);
        for (int k = 0; k < 380; k++) send_event(random_event());
        drain();

        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+design
design/mupm_pkg.sv
design/mupm_front.sv
design/mupm_back.sv
design/memory_usage_pressure_monitor.sv
tb/sv/memory_usage_pressure_monitor_tb.sv
